/* rtl/core/het_pkg.sv */
// Shared types, codes and constants of the hysteresis edge threshold unit.
package het_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [10:0] IMAGE_WIDTH_RST = 11'd1024;
	localparam logic [7:0] LOW_THRESHOLD_RST = 8'd50;
	localparam logic [7:0] HIGH_THRESHOLD_RST = 8'd150;
	localparam logic [7:0] EDGE_ON = 8'd255;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH = 2'd0,
		REG_LOW_THRESHOLD = 2'd1,
		REG_HIGH_THRESHOLD = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_LOW = 2'd0,
		CLS_WEAK = 2'd1,
		CLS_STRONG = 2'd2
	} cls_t;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_DUP = 2'd1,
		KIND_ZERO = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] low;
		logic [7:0] high;
	} thr_t;

	typedef struct packed {
		logic emit;
		logic lrep;
		logic rrep;
		logic trep;
		logic last;
	} judge_t;

	typedef struct packed {
		cls_t top;
		cls_t mid;
		cls_t bot;
		judge_t jd;
	} col_entry_t;

endpackage

/* rtl/core/het_if.sv */
// Stream interfaces for gradient pixels in and edge pixels out.
interface het_pix_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] pixel_in;
	modport source (output valid, output mode, output pixel_in, input ready);
	modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

interface het_edge_if;
	logic       valid;
	logic       ready;
	logic [7:0] edge_pixel;
	logic       frame_last;
	modport source (output valid, output edge_pixel, output frame_last, input ready);
	modport sink (input valid, input edge_pixel, input frame_last, output ready);
endinterface

/* rtl/core/het_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module het_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/het_front.sv */
// Front end: accept and classify pixels, track row/column/flush, read and update line stores.
module het_front import het_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH + 1),
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	het_pix_if.sink       pix,
	input  logic [CW-1:0] width_eff,
	input  thr_t          thr,
	output logic          push,
	output col_entry_t    push_entry,
	input  logic          q_full
);

	logic [CW-1:0] column_q;
	logic [1:0]    row_phase_q;
	logic [CW-1:0] flush_q;

	logic          s1_valid_q;
	kind_t         kind_s1;
	cls_t          cls_s1;
	logic [AW-1:0] addr_s1;
	judge_t        jd_s1;
	logic          byp_s1;
	cls_t          byp_up_s1;
	cls_t          byp_mid_s1;

	logic          accept;
	logic          s1_adv;
	logic          go;
	logic          do_take;
	kind_t         kind_n;
	cls_t          cls_n;
	logic [CW-1:0] addr_n;
	judge_t        jd_n;
	logic [CW-1:0] c0;
	logic [1:0]    rp0;
	logic [CW-1:0] c_inc;
	logic [CW-1:0] c_n;
	logic [1:0]    rp_n;
	logic [CW-1:0] fc_n;

	logic [3:0]    rdata;
	cls_t          up_eff;
	cls_t          mid_eff;
	logic          ram_we;
	logic          ram_re;

	function automatic logic [1:0] rp_inc(input logic [1:0] rp);
		return (rp == 2'd3) ? rp : rp + 2'd1;
	endfunction

	function automatic cls_t classify(input logic [7:0] p, input thr_t t);
		if (p <= t.low) begin
			return CLS_LOW;
		end
		if (p > t.high) begin
			return CLS_STRONG;
		end
		return CLS_WEAK;
	endfunction

	assign s1_adv = s1_valid_q && !q_full;
	assign pix.ready = !s1_valid_q || !q_full;
	assign accept = pix.valid && pix.ready;

	always_comb begin
		c0 = column_q;
		rp0 = row_phase_q;
		fc_n = flush_q;
		if (c0 >= width_eff) begin
			c0 = '0;
			rp0 = rp_inc(rp0);
		end
		go = 1'b0;
		do_take = 1'b0;
		kind_n = KIND_PIXEL;
		cls_n = CLS_LOW;
		addr_n = '0;
		jd_n = '0;
		if (!pix.mode) begin
			if (flush_q != '0) begin
				c0 = '0;
				rp0 = '0;
				fc_n = '0;
			end
			do_take = 1'b1;
			cls_n = classify(pix.pixel_in, thr);
		end else if (c0 != '0) begin
			do_take = 1'b1;
		end
		c_n = c0;
		rp_n = rp0;
		c_inc = c0 + CW'(1);
		if (do_take) begin
			go = 1'b1;
			addr_n = c0;
			if (c0 == '0) begin
				jd_n.emit = (rp0 >= 2'd2);
				jd_n.lrep = (width_eff == CW'(1));
				jd_n.rrep = 1'b1;
				jd_n.trep = (rp0 == 2'd2);
			end else begin
				jd_n.emit = (rp0 != 2'd0);
				jd_n.lrep = (c0 == CW'(1));
				jd_n.trep = (rp0 == 2'd1);
			end
			if (c_inc >= width_eff) begin
				c_n = '0;
				rp_n = rp_inc(rp0);
			end else begin
				c_n = c_inc;
			end
		end else if (pix.mode && rp0 != 2'd0) begin
			priority if (flush_q == '0) begin
				go = 1'b1;
				kind_n = KIND_DUP;
				jd_n.emit = (rp0 >= 2'd2);
				jd_n.lrep = (width_eff == CW'(1));
				jd_n.rrep = 1'b1;
				jd_n.trep = (rp0 == 2'd2);
				fc_n = CW'(1);
			end else if (flush_q < width_eff) begin
				go = 1'b1;
				kind_n = KIND_DUP;
				addr_n = flush_q;
				jd_n.emit = 1'b1;
				jd_n.lrep = (flush_q == CW'(1));
				jd_n.trep = (rp0 == 2'd1);
				fc_n = flush_q + CW'(1);
			end else begin
				if (flush_q == width_eff) begin
					go = 1'b1;
					kind_n = KIND_ZERO;
					jd_n.emit = 1'b1;
					jd_n.lrep = (flush_q == CW'(1));
					jd_n.rrep = 1'b1;
					jd_n.trep = (rp0 == 2'd1);
					jd_n.last = 1'b1;
				end
				c_n = '0;
				rp_n = '0;
				fc_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_phase_q <= '0;
			flush_q <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				column_q <= c_n;
				row_phase_q <= rp_n;
				flush_q <= fc_n;
				s1_valid_q <= go;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_n;
			cls_s1 <= cls_n;
			addr_s1 <= addr_n[AW-1:0];
			jd_s1 <= jd_n;
			byp_s1 <= s1_valid_q && (kind_s1 == KIND_PIXEL) && (addr_s1 == addr_n[AW-1:0]);
			byp_up_s1 <= mid_eff;
			byp_mid_s1 <= cls_s1;
		end
	end

	assign ram_re = accept && go && (kind_n != KIND_ZERO);
	assign ram_we = s1_adv && (kind_s1 == KIND_PIXEL);
	assign up_eff = byp_s1 ? byp_up_s1 : cls_t'(rdata[3:2]);
	assign mid_eff = byp_s1 ? byp_mid_s1 : cls_t'(rdata[1:0]);

	het_ram #(
		.WIDTH(4),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata({mid_eff, cls_s1}),
		.re   (ram_re),
		.raddr(addr_n[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		push_entry.jd = jd_s1;
		unique case (kind_s1)
			KIND_PIXEL: begin
				push_entry.top = up_eff;
				push_entry.mid = mid_eff;
				push_entry.bot = cls_s1;
			end
			KIND_DUP: begin
				push_entry.top = up_eff;
				push_entry.mid = mid_eff;
				push_entry.bot = mid_eff;
			end
			default: begin
				push_entry.top = CLS_LOW;
				push_entry.mid = CLS_LOW;
				push_entry.bot = CLS_LOW;
			end
		endcase
	end

	assign push = s1_adv;

	a_flush_at_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q != '0 |-> column_q == '0)
		else $error("flush sequence running mid-row");

	a_zero_col_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && kind_s1 == KIND_ZERO |-> jd_s1.last && jd_s1.emit)
		else $error("closing column without frame end");

endmodule

/* rtl/core/het_queue.sv */
// Short register queue of window columns between front and back ends.
module het_queue import het_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  col_entry_t din,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output col_entry_t dout
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	col_entry_t    slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full = (count_q == NW'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign dout = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue overflow");

endmodule

/* rtl/core/het_back.sv */
// Back end: 3x3 class window, hysteresis decision and output register.
module het_back import het_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  col_entry_t q_entry,
	output logic       pop,
	het_edge_if.source edges
);

	cls_t       win_q [3][3];
	cls_t       win_n [3][3];
	logic [1:0] cols [3];
	logic [1:0] rows [3];
	logic       hit;
	cls_t       centre;
	logic [7:0] edge_n;

	logic       out_valid_q;
	logic [7:0] edge_q;
	logic       last_q;
	logic       load;

	always_comb begin
		win_n[0] = win_q[1];
		win_n[1] = win_q[2];
		win_n[2][0] = q_entry.top;
		win_n[2][1] = q_entry.mid;
		win_n[2][2] = q_entry.bot;
		cols[0] = q_entry.jd.lrep ? 2'd1 : 2'd0;
		cols[1] = 2'd1;
		cols[2] = q_entry.jd.rrep ? 2'd1 : 2'd2;
		rows[0] = q_entry.jd.trep ? 2'd1 : 2'd0;
		rows[1] = 2'd1;
		rows[2] = 2'd2;
		hit = 1'b0;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				if (win_n[cols[a]][rows[b]] == CLS_STRONG) begin
					hit = 1'b1;
				end
			end
		end
		centre = win_n[1][1];
		edge_n = ((centre == CLS_STRONG) || (centre == CLS_WEAK && hit)) ? EDGE_ON : '0;
	end

	assign pop = q_valid && (!out_valid_q || edges.ready);
	assign load = pop && q_entry.jd.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					win_q[a][b] <= CLS_LOW;
				end
			end
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				win_q <= win_n;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (edges.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			edge_q <= edge_n;
			last_q <= q_entry.jd.last;
		end
	end

	assign edges.valid = out_valid_q;
	assign edges.edge_pixel = edge_q;
	assign edges.frame_last = last_q;

	a_edge_binary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (edge_q == '0 || edge_q == EDGE_ON))
		else $error("edge pixel neither 0 nor 255");

endmodule

/* rtl/core/hysteresis_edge_threshold_unit.sv */
// Top level of the hysteresis edge threshold unit: register port and block wiring.
//
// Gradient-magnitude pixels enter on pix (valid/ready, mode 0 = pixel, mode 1 = flush)
// in raster order; edge pixels (0 or 255) leave on edges with frame_last on the last
// pixel of a frame. Results lag the pixel stream by image_width+1 beats; after the
// last pixel of a frame send flush beats until frame_last appears (image_width+1).
// Throughput is one beat per cycle while pix.ready is high; the line-store RAM takes
// one read and one write per cycle. A result travels from the beat that completes its
// window through the line-store read and stage-1 registers, then the column queue,
// then the window decision into the output register that drives edges.
// A four-entry column queue separates the front end from the output side, so pix
// keeps flowing while edges stalls until the queue fills; then pix.ready drops.
// Reset clears the row, column and flush counters, the window and the registers
// (width 1024, thresholds 50 and 150); line-store contents stay undefined and need no
// clearing, since border replication keeps stale entries out of every result. The user
// must write registers over the APB port only while the stream is idle (not enforced).
module hysteresis_edge_threshold_unit import het_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	het_pix_if.sink     pix,
	het_edge_if.source  edges,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [10:0]   image_width_q;
	logic [CW-1:0] width_eff_q;
	thr_t          thr_q;
	logic          wr_en;

	logic          push;
	col_entry_t    push_entry;
	logic          q_full;
	logic          pop;
	logic          q_valid;
	col_entry_t    q_entry;

	function automatic logic [CW-1:0] eff_width(input logic [10:0] v);
		if (v == '0) begin
			return CW'(1);
		end
		if (32'(v) > 32'(MAX_WIDTH)) begin
			return CW'(MAX_WIDTH);
		end
		return CW'(v);
	endfunction

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			width_eff_q <= eff_width(IMAGE_WIDTH_RST);
			thr_q.low <= LOW_THRESHOLD_RST;
			thr_q.high <= HIGH_THRESHOLD_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[10:0];
					width_eff_q <= eff_width(pwdata[10:0]);
				end
				REG_LOW_THRESHOLD: thr_q.low <= pwdata[7:0];
				REG_HIGH_THRESHOLD: thr_q.high <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IMAGE_WIDTH: prdata = {21'b0, image_width_q};
			REG_LOW_THRESHOLD: prdata = {24'b0, thr_q.low};
			REG_HIGH_THRESHOLD: prdata = {24'b0, thr_q.high};
			default: prdata = '0;
		endcase
	end

	het_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.width_eff (width_eff_q),
		.thr       (thr_q),
		.push      (push),
		.push_entry(push_entry),
		.q_full    (q_full)
	);

	het_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_entry),
		.full  (q_full),
		.pop   (pop),
		.valid (q_valid),
		.dout  (q_entry)
	);

	het_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.pop    (pop),
		.edges  (edges)
	);

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Testbench for the hysteresis edge threshold unit: directed table, then random frames.
module testbench import het_pkg::*; ();

	localparam int SETTLE = 12;
	localparam int IDLE_PCT = 82;
	localparam int BOTH_PCT = 16;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	typedef enum logic {MODE_PIXEL = 1'b0, MODE_FLUSH = 1'b1} beat_mode_t;

	typedef struct packed {
		logic [7:0] level;
		logic       last;
	} edge_beat_t;

	typedef struct packed {
		logic        cfg;
		reg_idx_t    idx;
		logic [10:0] value;
		beat_mode_t  mode;
		logic [7:0]  px;
		logic        typed;
		edge_beat_t  want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	het_pix_if  pix();
	het_edge_if edges();

	hysteresis_edge_threshold_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.edges(edges),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cls_t        upper_cls [MAX_WIDTH_DEF];
	cls_t        middle_cls [MAX_WIDTH_DEF];
	logic [17:0] win_cls;
	int unsigned col_cnt;
	int unsigned row_ph;
	int unsigned flush_cnt;
	logic [10:0] cfg_width;
	logic [7:0]  cfg_low;
	logic [7:0]  cfg_high;
	edge_beat_t  pending_edges [$];
	int          errors = 0;
	bit          src_idle = 1'b0;
	bit          rx_stall = 1'b0;
	int          idle_pct = IDLE_PCT;

	always #2 clk = ~clk;

	function automatic int unsigned active_width();
		if (cfg_width == 0) return 1;
		if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
		return cfg_width;
	endfunction

	function automatic cls_t classify(logic [7:0] p);
		if (p <= cfg_low) return CLS_LOW;
		if (p > cfg_high) return CLS_STRONG;
		return CLS_WEAK;
	endfunction

	function automatic cls_t win_at(int c, int r);
		return cls_t'(win_cls[2 * (3 * c + r) +: 2]);
	endfunction

	function automatic void push_col(cls_t t, cls_t m, cls_t b);
		win_cls = {b, m, t, win_cls[17:6]};
	endfunction

	function automatic logic [7:0] verdict(int cc, bit lrep, bit rrep, bit trep);
		int   c;
		int   r;
		cls_t ctr;
		ctr = win_at(cc, 1);
		if (ctr == CLS_STRONG) return EDGE_ON;
		if (ctr != CLS_WEAK) return 8'd0;
		for (c = lrep ? cc : cc - 1; c <= (rrep ? cc : cc + 1); c++) begin
			for (r = trep ? 1 : 0; r <= 2; r++) begin
				if (win_at(c, r) == CLS_STRONG) return EDGE_ON;
			end
		end
		return 8'd0;
	endfunction

	function automatic void reset_frame();
		col_cnt = 0;
		row_ph = 0;
		flush_cnt = 0;
	endfunction

	function automatic bit absorb_pixel(cls_t k, int unsigned w, output edge_beat_t r);
		int unsigned c;
		bit          got;
		cls_t        u;
		cls_t        m;
		c = col_cnt;
		got = 1'b0;
		r = '0;
		if (c == 0 && row_ph >= 2) begin
			r.level = verdict(2, w == 1, 1'b1, row_ph == 2);
			got = 1'b1;
		end
		u = upper_cls[c];
		m = middle_cls[c];
		push_col(u, m, k);
		upper_cls[c] = m;
		middle_cls[c] = k;
		if (c >= 1 && row_ph >= 1) begin
			r.level = verdict(1, c == 1, 1'b0, row_ph == 1);
			got = 1'b1;
		end
		col_cnt = c + 1;
		if (col_cnt >= w) begin
			col_cnt = 0;
			if (row_ph < 3) row_ph++;
		end
		return got;
	endfunction

	function automatic bit predict_beat(beat_mode_t mode, logic [7:0] p, output edge_beat_t r);
		int unsigned w;
		int unsigned j;
		bit          got;
		w = active_width();
		r = '0;
		got = 1'b0;
		if (col_cnt >= w) begin
			col_cnt = 0;
			if (row_ph < 3) row_ph++;
		end
		if (mode == MODE_PIXEL) begin
			if (flush_cnt != 0) reset_frame();
			return absorb_pixel(classify(p), w, r);
		end
		if (col_cnt != 0) return absorb_pixel(CLS_LOW, w, r);
		if (row_ph == 0) return 1'b0;
		j = flush_cnt;
		if (j == 0) begin
			if (row_ph >= 2) begin
				r.level = verdict(2, w == 1, 1'b1, row_ph == 2);
				got = 1'b1;
			end
			push_col(upper_cls[0], middle_cls[0], middle_cls[0]);
			flush_cnt = 1;
			return got;
		end
		if (j < w) begin
			push_col(upper_cls[j], middle_cls[j], middle_cls[j]);
			r.level = verdict(1, j == 1, 1'b0, row_ph == 1);
			flush_cnt = j + 1;
			return 1'b1;
		end
		if (j == w) begin
			push_col(CLS_LOW, CLS_LOW, CLS_LOW);
			r.level = verdict(1, j == 1, 1'b1, row_ph == 1);
			r.last = 1'b1;
			reset_frame();
			return 1'b1;
		end
		reset_frame();
		return 1'b0;
	endfunction

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(3))
			0: return 8'($urandom_range(int'(cfg_low)));
			1: return (cfg_high > cfg_low) ?
				8'($urandom_range(int'(cfg_high), int'(cfg_low) + 1)) : 8'($urandom_range(255));
			2: return (cfg_high < 8'd255) ? 8'($urandom_range(255, int'(cfg_high) + 1)) : 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic stim_row_t cfg_row(reg_idx_t idx, logic [10:0] value);
		stim_row_t s;
		s = '0;
		s.cfg = 1'b1;
		s.idx = idx;
		s.value = value;
		return s;
	endfunction

	function automatic stim_row_t beat_row(beat_mode_t mode, logic [7:0] px);
		stim_row_t s;
		s = '0;
		s.mode = mode;
		s.px = px;
		return s;
	endfunction

	function automatic stim_row_t known_row(beat_mode_t mode, logic [7:0] level, logic last);
		stim_row_t s;
		s = '0;
		s.mode = mode;
		s.typed = 1'b1;
		s.want.level = level;
		s.want.last = last;
		return s;
	endfunction

	task automatic send_beat(beat_mode_t mode, logic [7:0] p, bit typed, edge_beat_t want);
		edge_beat_t r;
		@(negedge clk);
		while (src_idle && $urandom_range(99) < idle_pct) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.mode <= mode;
		pix.pixel_in <= p;
		do @(posedge clk); while (pix.ready !== 1'b1);
		if (predict_beat(mode, p, r)) pending_edges.push_back(typed ? want : r);
	endtask

	task automatic drain_results();
		@(negedge clk);
		pix.valid <= 1'b0;
		while (pending_edges.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [10:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_IMAGE_WIDTH: cfg_width = value;
			REG_LOW_THRESHOLD: cfg_low = value[7:0];
			REG_HIGH_THRESHOLD: cfg_high = value[7:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_frame(inout int sent);
		int unsigned w;
		int unsigned npx;
		int unsigned nfl;
		w = active_width();
		npx = ((w > 64) ? 1 : $urandom_range(4, 1)) * w;
		nfl = w + 1;
		case ($urandom_range(9))
			0: npx = $urandom_range(npx, 1);
			1: nfl = $urandom_range(w, 0);
			2: repeat ($urandom_range(2, 1)) send_beat(MODE_FLUSH, 8'($urandom), 1'b0, '0);
			default: ;
		endcase
		repeat (npx) begin
			send_beat(MODE_PIXEL, pick_pixel(), 1'b0, '0);
			sent++;
		end
		repeat (nfl) begin
			send_beat(MODE_FLUSH, 8'($urandom), 1'b0, '0);
			sent++;
		end
		if ($urandom_range(7) == 0) drain_results();
	endtask

	task automatic run_phase(int width, int lo, int hi, idle_mode_t idle, int budget);
		int sent;
		drain_results();
		write_reg(REG_IMAGE_WIDTH, 11'(width));
		write_reg(REG_LOW_THRESHOLD, 11'(lo));
		write_reg(REG_HIGH_THRESHOLD, 11'(hi));
		src_idle = (idle == IDLE_SEND || idle == IDLE_BOTH);
		rx_stall = (idle == IDLE_RECV || idle == IDLE_BOTH);
		idle_pct = (idle == IDLE_BOTH) ? BOTH_PCT : IDLE_PCT;
		sent = 0;
		while (sent < budget) run_frame(sent);
		while (col_cnt != 0 || row_ph != 0) send_beat(MODE_FLUSH, 8'd0, 1'b0, '0);
	endtask

	initial begin
		edges.ready = 1'b0;
		forever begin
			@(negedge clk);
			edges.ready <= !(rx_stall && $urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk) begin
		edge_beat_t want;
		if (arst_n && edges.valid === 1'b1 && edges.ready) begin
			if (pending_edges.size() == 0) begin
				$error("edge beat with nothing pending: edge_pixel %0d, frame_last %0b",
					edges.edge_pixel, edges.frame_last);
				errors++;
			end else begin
				want = pending_edges.pop_front();
				if (edges.edge_pixel !== want.level) begin
					$error("edge_pixel: expected %0d, got %0d", want.level, edges.edge_pixel);
					errors++;
				end
				if (edges.frame_last !== want.last) begin
					$error("frame_last: expected %0b, got %0b", want.last, edges.frame_last);
					errors++;
				end
			end
		end
	end

	initial begin
		stim_row_t directed [45];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix.valid = 1'b0;
		pix.mode = 1'b0;
		pix.pixel_in = '0;
		cfg_width = IMAGE_WIDTH_RST;
		cfg_low = LOW_THRESHOLD_RST;
		cfg_high = HIGH_THRESHOLD_RST;
		win_cls = '0;
		reset_frame();
		foreach (upper_cls[i]) begin
			upper_cls[i] = CLS_LOW;
			middle_cls[i] = CLS_LOW;
		end
		directed = '{
			cfg_row(REG_IMAGE_WIDTH, 11'd0),
			beat_row(MODE_PIXEL, 8'd255),
			beat_row(MODE_PIXEL, 8'd0),
			known_row(MODE_FLUSH, EDGE_ON, 1'b0),
			known_row(MODE_FLUSH, 8'd0, 1'b1),
			beat_row(MODE_FLUSH, 8'd0),
			cfg_row(REG_IMAGE_WIDTH, 11'd2),
			beat_row(MODE_PIXEL, 8'd100),
			beat_row(MODE_PIXEL, 8'd255),
			beat_row(MODE_PIXEL, 8'd51),
			beat_row(MODE_FLUSH, 8'd0),
			beat_row(MODE_FLUSH, 8'd255),
			beat_row(MODE_PIXEL, 8'd150),
			beat_row(MODE_PIXEL, 8'd151),
			beat_row(MODE_FLUSH, 8'd0),
			beat_row(MODE_FLUSH, 8'd0),
			known_row(MODE_FLUSH, EDGE_ON, 1'b1),
			cfg_row(REG_LOW_THRESHOLD, 11'd200),
			cfg_row(REG_HIGH_THRESHOLD, 11'd100),
			cfg_row(REG_IMAGE_WIDTH, 11'd1),
			beat_row(MODE_PIXEL, 8'd200),
			beat_row(MODE_PIXEL, 8'd201),
			known_row(MODE_FLUSH, 8'd0, 1'b0),
			known_row(MODE_FLUSH, EDGE_ON, 1'b1),
			cfg_row(REG_LOW_THRESHOLD, 11'd50),
			cfg_row(REG_HIGH_THRESHOLD, 11'd150),
			cfg_row(REG_IMAGE_WIDTH, 11'd3),
			beat_row(MODE_PIXEL, 8'd10),
			beat_row(MODE_PIXEL, 8'd160),
			beat_row(MODE_PIXEL, 8'd120),
			beat_row(MODE_PIXEL, 8'd90),
			cfg_row(REG_IMAGE_WIDTH, 11'd1),
			beat_row(MODE_PIXEL, 8'd130),
			beat_row(MODE_FLUSH, 8'd0),
			beat_row(MODE_FLUSH, 8'd0),
			cfg_row(REG_IMAGE_WIDTH, 11'd2047),
			beat_row(MODE_PIXEL, 8'd200),
			beat_row(MODE_PIXEL, 8'd40),
			beat_row(MODE_PIXEL, 8'd120),
			beat_row(MODE_PIXEL, 8'd170),
			cfg_row(REG_IMAGE_WIDTH, 11'd3),
			beat_row(MODE_FLUSH, 8'd0),
			beat_row(MODE_FLUSH, 8'd0),
			beat_row(MODE_FLUSH, 8'd0),
			beat_row(MODE_FLUSH, 8'd0)
		};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) begin
			if (directed[i].cfg) begin
				drain_results();
				write_reg(directed[i].idx, directed[i].value);
			end else begin
				send_beat(directed[i].mode, directed[i].px, directed[i].typed, directed[i].want);
			end
		end
		run_phase(5, 50, 150, IDLE_NONE, 85);
		run_phase(1, 0, 0, IDLE_SEND, 85);
		run_phase(16, 100, 180, IDLE_RECV, 85);
		run_phase(4, 255, 255, IDLE_BOTH, 85);
		run_phase(9, 30, 200, IDLE_SEND, 85);
		run_phase(2, 120, 60, IDLE_RECV, 85);
		run_phase(3, 0, 255, IDLE_BOTH, 85);
		run_phase(7, 60, 61, IDLE_NONE, 85);
		drain_results();
		if (errors == 0) begin
			$display("PASS hysteresis_edge_threshold_unit");
		end else begin
			$display("FAIL hysteresis_edge_threshold_unit");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("FAIL hysteresis_edge_threshold_unit");
		$finish;
	end

endmodule
